// ----- rtl/core/fdss_pkg.sv -----
// fdss_pkg: shared types, constants and the segment glyph table for the
// four-digit seven-segment scanner. No dependencies.
package fdss_pkg;

  localparam int DIGIT_W  = 4;
  localparam int NUMBER_W = 16;
  localparam int POS_W    = 3;
  localparam int BYTE_W   = 8;

  // Input mode codes
  localparam logic [1:0] MODE_SET_NUMBER = 2'd0;
  localparam logic [1:0] MODE_SET_DIGIT  = 2'd1;
  localparam logic [1:0] MODE_SCAN       = 2'd2;

  // Work carried from the front end to the back end
  typedef enum logic [1:0] {
    CMD_NUMBER,
    CMD_DIGIT,
    CMD_SCAN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [NUMBER_W-1:0]   number;
    logic [POS_W-1:0]      position;
    logic [DIGIT_W-1:0]    digit;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_SCAN
  } back_state_t;

  // Segment bits: bit0 = a ... bit6 = g; non-decimal codes are blank
  function automatic logic [BYTE_W-1:0] seg_glyph(logic [DIGIT_W-1:0] d);
    logic [BYTE_W-1:0] pat;
    unique case (d)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/core/fdss_front.sv -----
// fdss_front: decodes input beats into commands, clamps the number and
// drops requests that change nothing. Depends on fdss_pkg.
module fdss_front import fdss_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic [NUMBER_W-1:0] number_value,
  input  logic [POS_W-1:0]    digit_position,
  input  logic [DIGIT_W-1:0]  digit_value,
  input  logic                q_full,
  output logic                q_push,
  output cmd_t                q_cmd
);

  // Largest value the digits can show; the 16-bit input never needs more
  // than five digits
  function automatic int unsigned max_shown(int n);
    int unsigned lim;
    lim = 1;
    for (int k = 0; k < 8; k++) begin
      if (k < n && lim <= 65536) lim = lim * 10;
    end
    return lim - 1;
  endfunction

  localparam int unsigned MAX_SHOWN = max_shown(DIGIT_COUNT);
  localparam logic [NUMBER_W:0] MAX_WIDE = (NUMBER_W+1)'(MAX_SHOWN);

  logic keep;
  logic clamp;

  assign in_ready = !q_full;
  assign clamp    = {1'b0, number_value} > MAX_WIDE;

  always_comb begin
    keep          = 1'b0;
    q_cmd.kind     = CMD_SCAN;
    q_cmd.number   = clamp ? MAX_WIDE[NUMBER_W-1:0] : number_value;
    q_cmd.position = digit_position;
    q_cmd.digit    = digit_value;
    unique case (mode)
      MODE_SET_NUMBER: begin
        keep       = 1'b1;
        q_cmd.kind = CMD_NUMBER;
      end
      MODE_SET_DIGIT: begin
        keep       = (32'(digit_position) < DIGIT_COUNT) && (digit_value < 4'd10);
        q_cmd.kind = CMD_DIGIT;
      end
      MODE_SCAN: begin
        keep       = 1'b1;
        q_cmd.kind = CMD_SCAN;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = in_valid && in_ready && keep;

endmodule

// ----- rtl/core/fdss_queue.sv -----
// fdss_queue: two-entry command queue between front and back end.
// Depends on fdss_pkg.
module fdss_queue import fdss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
                                  (push && !pop && !full) |=> count == $past(count) + 2'd1)
    else $error("queue count lost a push");

endmodule

// ----- rtl/core/fdss_back.sv -----
// fdss_back: digit store, decimal split (one digit per cycle) and scan
// sequencer with output register. Depends on fdss_pkg.
module fdss_back import fdss_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               common_anode,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  digit_select,
  output logic [BYTE_W-1:0]  segment_pattern,
  output logic               last_digit
);

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(DIGIT_COUNT - 1);
  localparam logic [BYTE_W-1:0] LAST_SELECT = BYTE_W'(8'h80 >> (DIGIT_COUNT - 1));
  localparam logic [16:0]       RECIP_10    = 17'd52429;  // 2^19 / 10, rounded up

  back_state_t         state, state_next;
  logic [DIGIT_W-1:0]  store [DIGIT_COUNT];
  logic [IDX_W-1:0]    cnt;
  logic [NUMBER_W-1:0] work;

  logic                slot_free;
  logic                load_out;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [DIGIT_W-1:0]  wr_data;
  logic [32:0]         product;
  logic [NUMBER_W-1:0] quot;
  logic [NUMBER_W-1:0] rem_wide;
  logic [BYTE_W-1:0]   pat;

  // x / 10 by reciprocal, exact for every 16-bit x
  assign product  = {17'd0, work} * {16'd0, RECIP_10};
  assign quot     = NUMBER_W'(product >> 19);
  assign rem_wide = work - ((quot << 3) + (quot << 1));

  assign slot_free = !out_valid || out_ready;
  assign pat       = seg_glyph(store[cnt]);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            CMD_NUMBER: state_next = ST_SPLIT;
            CMD_SCAN:   state_next = ST_SCAN;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SPLIT: if (cnt == '0) state_next = ST_IDLE;
      ST_SCAN:  if (slot_free && cnt == LAST_IDX) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = cnt;
    wr_data  = rem_wide[DIGIT_W-1:0];
    unique case (state)
      ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid && q_cmd.kind == CMD_DIGIT) begin
          wr_en   = 1'b1;
          wr_idx  = q_cmd.position[IDX_W-1:0];
          wr_data = q_cmd.digit;
        end
      end
      ST_SPLIT: wr_en = 1'b1;
      ST_SCAN:  load_out = slot_free;
      default:  q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && q_valid) begin
        cnt <= (q_cmd.kind == CMD_NUMBER) ? LAST_IDX : '0;
      end else if (state == ST_SPLIT) begin
        cnt <= cnt - 1'b1;
      end else if (load_out && cnt != LAST_IDX) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) work <= q_cmd.number;
    else if (state == ST_SPLIT)      work <= quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIGIT_COUNT; k++) store[k] <= '0;
    end else if (wr_en) begin
      store[wr_idx] <= wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      digit_select    <= BYTE_W'(8'h80 >> cnt);
      segment_pattern <= common_anode ? ~pat : pat;
      last_digit      <= cnt == LAST_IDX;
    end
  end

  a_scan_loads: assert property (@(posedge clk) disable iff (rst)
                                 (state == ST_SCAN && slot_free) |=> out_valid)
    else $error("scan step did not produce a beat");
  a_last_select: assert property (@(posedge clk) disable iff (rst)
                                  (out_valid && last_digit) |-> digit_select == LAST_SELECT)
    else $error("last beat carries wrong digit select");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
                                  q_pop |-> state == ST_IDLE)
    else $error("command taken while back end busy");

endmodule

// ----- rtl/core/four_digit_seven_segment_scanner.sv -----
// four_digit_seven_segment_scanner: top level of the multiplexed display
// scanner. Depends on fdss_pkg, fdss_front, fdss_queue, fdss_back.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid / in_ready    | mode, number_value, digit_position,
//           |                        | digit_value
//   out     | out_valid / out_ready  | digit_select, segment_pattern, last_digit
//   cfg     | cfg_write_en           | cfg_write_data (common_anode)
//
// A command reaches the back end through the queue. Set-digit is written as
//   the command is taken; set-number takes the command, then one digit a cycle
//   from the divide-by-10 unit; scan takes the command, then one beat per cycle
//   into the output register while free.
// Front end accepts into a two-entry command queue, so input is taken while
//   the back end works; mode 3 and out-of-range set-digit beats are dropped.
// Reset (rst, synchronous): digit store cleared to zeros, common cathode.
// A stalled output holds the scan sequencer; the queue then fills and
//   in_ready drops.
module four_digit_seven_segment_scanner import fdss_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic                cfg_write_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic [NUMBER_W-1:0] number_value,
  input  logic [POS_W-1:0]    digit_position,
  input  logic [DIGIT_W-1:0]  digit_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   digit_select,
  output logic [BYTE_W-1:0]   segment_pattern,
  output logic                last_digit
);

  logic common_anode;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // polarity register, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      common_anode <= 1'b0;
    end else if (cfg_write_en) begin
      common_anode <= cfg_write_data;
    end
  end

  fdss_front #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .number_value   (number_value),
    .digit_position (digit_position),
    .digit_value    (digit_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  fdss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head_cmd)
  );

  // back end owns the digit store and the output register
  fdss_back #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .common_anode    (common_anode),
    .q_valid         (q_valid),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .digit_select    (digit_select),
    .segment_pattern (segment_pattern),
    .last_digit      (last_digit)
  );

endmodule

// ----- tb/four_digit_seven_segment_scanner_tb.sv -----
`timescale 1ns / 100ps
// four_digit_seven_segment_scanner_tb: self-checking bench for the display scanner.
// Depends on fdss_pkg and four_digit_seven_segment_scanner; drives a directed table
// and then random traffic, and checks every output beat against a local predictor.
module four_digit_seven_segment_scanner_tb;
  import fdss_pkg::*;

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int          NUM_DIGITS     = 4;
  localparam int          MAX_SHOWN      = 9999;   // largest value four digits show
  localparam logic [1:0]  MODE_UNUSED    = 2'd3;   // opcode with no meaning, must be dropped
  localparam int          DRAIN_CYCLES   = 16;     // back end may still chew on a set-number
  localparam int          LONG_HOLD      = 80;     // one long sink stall, in cycles
  localparam int          WATCHDOG_LIMIT = 2000;   // cycles with no beat on either side
  localparam logic [7:0]  SINK_PATTERN   = 8'b1101_0110;

  // Glyphs for digits 0..9, digit 0 in the low byte; bit0 = a ... bit6 = g
  localparam logic [79:0] GLYPHS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                    8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

  // One beat on the output side
  typedef struct packed {
    logic [BYTE_W-1:0] sel;
    logic [BYTE_W-1:0] seg;
    logic              last;
  } disp_beat_t;

  // One row of the directed table; segs holds position 0 in the top byte and
  // is only used when typed is set (scan rows whose answer is obvious)
  typedef struct packed {
    logic [1:0]          mode;
    logic [NUMBER_W-1:0] number;
    logic [POS_W-1:0]    position;
    logic [DIGIT_W-1:0]  digit;
    bit                  typed;
    logic [31:0]         segs;
  } stim_row_t;

  localparam int DIR_N = 22;

  stim_row_t dir_rows [DIR_N] = '{
    // freshly reset store reads 0000
    '{MODE_SCAN,       16'h0000, 3'd0, 4'd0,  1'b1, 32'h3F3F3F3F},
    // all ones on every field: number saturates to 9999
    '{MODE_SET_NUMBER, 16'hFFFF, 3'd7, 4'hF,  1'b0, 32'h0},
    '{MODE_SCAN,       16'hFFFF, 3'd7, 4'hF,  1'b1, 32'h6F6F6F6F},
    // zero on every field
    '{MODE_SET_NUMBER, 16'h0000, 3'd0, 4'd0,  1'b0, 32'h0},
    '{MODE_SCAN,       16'h0000, 3'd0, 4'd0,  1'b1, 32'h3F3F3F3F},
    // just past the clamp point
    '{MODE_SET_NUMBER, 16'd10000, 3'd0, 4'd0, 1'b0, 32'h0},
    '{MODE_SCAN,       16'h0000, 3'd0, 4'd0,  1'b1, 32'h6F6F6F6F},
    // right at the clamp point, then ordinary values covering every glyph
    '{MODE_SET_NUMBER, 16'd9999, 3'd0, 4'd0,  1'b0, 32'h0},
    '{MODE_SET_NUMBER, 16'd1234, 3'd0, 4'd0,  1'b0, 32'h0},
    '{MODE_SCAN,       16'h0000, 3'd0, 4'd0,  1'b0, 32'h0},
    '{MODE_SET_NUMBER, 16'd5678, 3'd0, 4'd0,  1'b0, 32'h0},
    '{MODE_SCAN,       16'h0000, 3'd0, 4'd0,  1'b0, 32'h0},
    '{MODE_SET_NUMBER, 16'd9012, 3'd0, 4'd0,  1'b0, 32'h0},
    '{MODE_SCAN,       16'h0000, 3'd0, 4'd0,  1'b0, 32'h0},
    // single-digit writes at both ends of the legal range
    '{MODE_SET_DIGIT,  16'h0000, 3'd0, 4'd9,  1'b0, 32'h0},
    '{MODE_SET_DIGIT,  16'h0000, 3'd3, 4'd0,  1'b0, 32'h0},
    // position out of range: dropped
    '{MODE_SET_DIGIT,  16'h0000, 3'd4, 4'd5,  1'b0, 32'h0},
    '{MODE_SET_DIGIT,  16'hFFFF, 3'd7, 4'hF,  1'b0, 32'h0},
    // digit out of range: dropped
    '{MODE_SET_DIGIT,  16'h0000, 3'd1, 4'd10, 1'b0, 32'h0},
    '{MODE_SET_DIGIT,  16'h0000, 3'd2, 4'hF,  1'b0, 32'h0},
    // unused opcode with everything set: no effect
    '{MODE_UNUSED,     16'hFFFF, 3'd7, 4'hF,  1'b0, 32'h0},
    '{MODE_SCAN,       16'h0000, 3'd0, 4'd0,  1'b0, 32'h0}
  };

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic                clk;
  logic                rst;
  logic                cfg_write_en;
  logic                cfg_write_data;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          mode;
  logic [NUMBER_W-1:0] number_value;
  logic [POS_W-1:0]    digit_position;
  logic [DIGIT_W-1:0]  digit_value;
  logic                out_valid;
  logic                out_ready;
  logic [BYTE_W-1:0]   digit_select;
  logic [BYTE_W-1:0]   segment_pattern;
  logic                last_digit;

  four_digit_seven_segment_scanner #(.DIGIT_COUNT(NUM_DIGITS)) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .number_value    (number_value),
    .digit_position  (digit_position),
    .digit_value     (digit_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .digit_select    (digit_select),
    .segment_pattern (segment_pattern),
    .last_digit      (last_digit)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: the digit store and the anode setting as the DUT should
  // hold them, plus the display beats still owed by the DUT
  // ---------------------------------------------------------------------------
  logic [DIGIT_W-1:0] shown_digits [NUM_DIGITS];
  bit                 anode_mode;
  disp_beat_t         pending_beats [$];

  int  err_count;
  int  beats_in;
  int  scan_runs;
  int  beats_checked;
  int  anode_writes;
  int  burst_left;
  int  holds_requested;
  int  holds_granted;

  // Update the digit store / queue expected scan beats for one accepted beat
  function automatic void track_display(logic [1:0] m, logic [NUMBER_W-1:0] n,
                                        logic [POS_W-1:0] p, logic [DIGIT_W-1:0] d,
                                        bit typed, logic [31:0] typed_segs);
    int         val;
    logic [7:0] pat;
    disp_beat_t b;
    case (m)
      MODE_SET_NUMBER: begin
        val = (n > MAX_SHOWN) ? MAX_SHOWN : int'(n);
        for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
          shown_digits[k] = DIGIT_W'(val % 10);
          val = val / 10;
        end
      end
      MODE_SET_DIGIT: begin
        if (p < NUM_DIGITS && d < 10) shown_digits[p] = d;
      end
      MODE_SCAN: begin
        scan_runs++;
        for (int k = 0; k < NUM_DIGITS; k++) begin
          if (typed) begin
            pat = typed_segs[31 - 8*k -: 8];
          end else begin
            // codes above 9 would be blank; the store never holds them
            pat = (shown_digits[k] < 10) ? GLYPHS[8*shown_digits[k] +: 8] : 8'h00;
          end
          if (anode_mode) pat = ~pat;
          b.sel  = 8'h80 >> k;
          b.seg  = pat;
          b.last = (k == NUM_DIGITS - 1);
          pending_beats.push_back(b);
        end
      end
      default: ;  // unused opcode: nothing happens
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Called at a rising edge; returns at the edge where the beat
  // was taken. Valid stays up across back-to-back beats with no re-toggle.
  // ---------------------------------------------------------------------------
  task automatic offer_beat(logic [1:0] m, logic [NUMBER_W-1:0] n, logic [POS_W-1:0] p,
                            logic [DIGIT_W-1:0] d, bit typed, logic [31:0] typed_segs);
    in_valid       <= 1'b1;
    mode           <= m;
    number_value   <= n;
    digit_position <= p;
    digit_value    <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_in++;
    track_display(m, n, p, d, typed, typed_segs);
  endtask

  // Bursts of random length separated by random gaps; sometimes a long
  // burst with no gap at all
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(20, 40);
      end else begin
        gap        = $urandom_range(0, 10);
        burst_left = $urandom_range(1, 10);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Park the sender until every owed beat is out, then let the back end settle
  // (set-number / dropped beats leave no trace on the output)
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // Single-cycle register write; only called while the block is idle
  task automatic write_anode(bit v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    anode_mode     =  v;
    anode_writes++;
  endtask

  // Random beat: mostly legal writes and scans with random content, the rest
  // out-of-range writes and the unused opcode. Returns 0 for beats the block drops.
  task automatic offer_random_beat(output bit effective);
    logic [1:0]          m;
    logic [NUMBER_W-1:0] n;
    logic [POS_W-1:0]    p;
    logic [DIGIT_W-1:0]  d;
    int                  pick;
    pick = $urandom_range(0, 99);
    // fields a command does not use carry noise
    n = NUMBER_W'($urandom());
    p = POS_W'($urandom());
    d = DIGIT_W'($urandom());
    if (pick < 35) begin
      m = MODE_SET_DIGIT;
      if ($urandom_range(0, 5) != 0) begin
        p = POS_W'($urandom_range(0, NUM_DIGITS - 1));
        d = DIGIT_W'($urandom_range(0, 9));
      end
    end else if (pick < 55) begin
      m = MODE_SET_NUMBER;
      case ($urandom_range(0, 3))
        0, 1:    n = NUMBER_W'($urandom_range(0, MAX_SHOWN));
        2:       n = NUMBER_W'($urandom_range(MAX_SHOWN + 1, 65535));
        default: ;  // raw 16-bit value
      endcase
    end else if (pick < 95) begin
      m = MODE_SCAN;
    end else begin
      m = MODE_UNUSED;
    end
    effective = (m == MODE_SET_NUMBER) || (m == MODE_SCAN) ||
                (m == MODE_SET_DIGIT && p < NUM_DIGITS && d < 10);
    pace_sender();
    offer_beat(m, n, p, d, 1'b0, 32'h0);
  endtask

  task automatic run_random_phase(int target);
    int done;
    bit eff;
    done = 0;
    while (done < target) begin
      offer_random_beat(eff);
      if (eff) done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= 1'b0;
    in_valid       <= 1'b0;
    mode           <= MODE_SET_NUMBER;
    number_value   <= '0;
    digit_position <= '0;
    digit_value    <= '0;
    err_count       = 0;
    beats_in        = 0;
    scan_runs       = 0;
    beats_checked   = 0;
    anode_writes    = 0;
    burst_left      = 0;
    holds_requested = 0;
    anode_mode      = 1'b0;
    for (int k = 0; k < NUM_DIGITS; k++) shown_digits[k] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // cathode mode for the directed table
    write_anode(1'b0);
    for (int i = 0; i < DIR_N; i++) begin
      pace_sender();
      offer_beat(dir_rows[i].mode, dir_rows[i].number, dir_rows[i].position,
                 dir_rows[i].digit, dir_rows[i].typed, dir_rows[i].segs);
    end
    wait_for_idle();

    // phase A: anode
    write_anode(1'b1);
    run_random_phase(30);
    wait_for_idle();

    // phase B: cathode, opened by a long sink stall while scans keep coming,
    // so the command queue fills and in_ready drops
    write_anode(1'b0);
    holds_requested++;
    for (int i = 0; i < 6; i++) offer_beat(MODE_SCAN, NUMBER_W'($urandom()),
                                           POS_W'($urandom()), DIGIT_W'($urandom()),
                                           1'b0, 32'h0);
    run_random_phase(30);
    wait_for_idle();

    // phase C: back to anode
    write_anode(1'b1);
    run_random_phase(30);
    wait_for_idle();

    err_count += pending_beats.size();
    $display("Run: %0d input beats, %0d scans, %0d display beats checked,", beats_in,
             scan_runs, beats_checked);
    $display("     %0d anode/cathode switches, one long sink stall, %0d errors.",
             anode_writes, err_count);
    if (err_count == 0) begin
      $display("** four_digit_seven_segment_scanner: PASSED **");
    end else begin
      $display("** four_digit_seven_segment_scanner: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sink pacing: windows of different stall styles, plus one long hold on
  // request from the main sequence
  // ---------------------------------------------------------------------------
  initial begin : sink_pacing
    int style;
    int window;
    int tick;
    style  = 0;
    window = 0;
    tick   = 0;
    holds_granted = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_granted != holds_requested) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_granted++;
      end else begin
        if (window == 0) begin
          style  = $urandom_range(0, 3);
          window = $urandom_range(16, 64);
        end
        window--;
        case (style)
          0:       out_ready <= 1'b1;                        // no stalls
          1:       out_ready <= SINK_PATTERN[tick % 8];      // fixed rhythm
          2:       out_ready <= 1'($urandom_range(0, 1));    // coin flip
          default: out_ready <= ($urandom_range(0, 3) == 0); // mostly stalled
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output checker: each beat against the oldest owed beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    disp_beat_t exp_b;
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat sel=%02h seg=%02h last=%0b", $time,
                 digit_select, segment_pattern, last_digit);
      end else begin
        exp_b = pending_beats.pop_front();
        beats_checked++;
        if (digit_select !== exp_b.sel) begin
          err_count++;
          $display("%0t: digit_select expected %02h actual %02h", $time, exp_b.sel,
                   digit_select);
        end
        if (segment_pattern !== exp_b.seg) begin
          err_count++;
          $display("%0t: segment_pattern expected %02h actual %02h", $time, exp_b.seg,
                   segment_pattern);
        end
        if (last_digit !== exp_b.last) begin
          err_count++;
          $display("%0t: last_digit expected %0b actual %0b", $time, exp_b.last,
                   last_digit);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without a beat on either side means a hang
  // ---------------------------------------------------------------------------
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
      $display("** four_digit_seven_segment_scanner: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
